// ===== rtl/core/rbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types, codes and sizes of the reorder buffer commit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

    // Buffer geometry
    localparam int ROB_DEPTH    = 64;
    localparam int RETIRE_WIDTH = 4;
    localparam int IDX_W        = $clog2(ROB_DEPTH);
    localparam int CNT_W        = $clog2(RETIRE_WIDTH) + 1;

    // Field widths of the channels
    localparam int CMD_W   = 2;
    localparam int EKIND_W = 2;
    localparam int AREG_W  = 5;
    localparam int ALIAS_W = 7;
    localparam int SID_W   = 8;
    localparam int SLOT_W  = 6;
    localparam int RKIND_W = 3;
    localparam int ERR_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_RESOLVE = 2'd2,
        CMD_COMMIT  = 2'd3
    } t_cmd;

    typedef enum logic [EKIND_W-1:0] {
        EK_REG    = 2'd0,
        EK_STORE  = 2'd1,
        EK_BRANCH = 2'd2
    } t_ekind;

    typedef enum logic [RKIND_W-1:0] {
        RK_ALLOC_ACK = 3'd0,
        RK_MARK_ACK  = 3'd1,
        RK_RET_REG   = 3'd2,
        RK_RET_STORE = 3'd3,
        RK_RET_BR    = 3'd4,
        RK_FLUSH     = 3'd5,
        RK_NONE      = 3'd6
    } t_rkind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_NOT_VALID  = 2'd1,
        ERR_NOT_BRANCH = 2'd2,
        ERR_FULL       = 2'd3
    } t_err;

    // One buffer entry as kept in the entry memory
    typedef struct packed {
        t_ekind               kind;
        logic                 wrong_path;
        logic [AREG_W-1:0]    dest_reg;
        logic [ALIAS_W-1:0]   fresh_alias;
        logic [ALIAS_W-1:0]   stale_alias;
        logic [SID_W-1:0]     store_tag;
    } t_entry;

    // One result item
    typedef struct packed {
        t_rkind               kind;
        logic [SLOT_W-1:0]    slot;
        logic [AREG_W-1:0]    retire_arch_reg;
        logic [ALIAS_W-1:0]   retire_new_alias;
        logic [ALIAS_W-1:0]   freed_alias;
        logic [SID_W-1:0]     store_to_run;
        t_err                 error_code;
        logic                 is_full;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/rbc_chan_if.sv =====
// ----------------------------------------------------------------------------
// rbc_chan_if
// Command and result channels of the reorder buffer commit unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbc_in_if;
    import rbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [EKIND_W-1:0]   entry_kind;
    logic [AREG_W-1:0]    arch_reg;
    logic [ALIAS_W-1:0]   fresh_phys;
    logic [ALIAS_W-1:0]   stale_phys;
    logic [SID_W-1:0]     store_id;
    logic [SLOT_W-1:0]    entry_index;
    logic                 mispredicted;

    modport source (
        output valid, cmd, entry_kind, arch_reg, fresh_phys, stale_phys,
               store_id, entry_index, mispredicted,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_kind, arch_reg, fresh_phys, stale_phys,
               store_id, entry_index, mispredicted,
        output ready
    );
endinterface

interface rbc_out_if;
    import rbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RKIND_W-1:0]   kind;
    logic [SLOT_W-1:0]    slot;
    logic [AREG_W-1:0]    retire_arch_reg;
    logic [ALIAS_W-1:0]   retire_new_alias;
    logic [ALIAS_W-1:0]   freed_alias;
    logic [SID_W-1:0]     store_to_run;
    logic [ERR_W-1:0]     error_code;
    logic                 is_full;
    logic                 last;

    modport source (
        output valid, kind, slot, retire_arch_reg, retire_new_alias,
               freed_alias, store_to_run, error_code, is_full, last,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, retire_arch_reg, retire_new_alias,
               freed_alias, store_to_run, error_code, is_full, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/reorder_buffer_commit_unit.sv =====
// ----------------------------------------------------------------------------
// reorder_buffer_commit_unit
// Circular reorder buffer with in-order retirement of up to four entries.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command per transfer: allocate, mark ready, resolve
//   branch or commit. o_out returns the results, the final one of each
//   command flagged by last. Both channels use valid/ready.
//   Allocate and mark: one result, loaded into the output register in the
//   cycle of the transfer; a new command may follow every cycle while the
//   output register can take a result.
//   Resolve branch: the entry kind is read from the entry memory and, for a
//   branch, written back with the outcome; an invalid slot needs no read.
//   Commit: one memory read of the head entry, then one result per retired
//   entry (up to 4), the next entry read as each one retires, or a single
//   result when the head is not ready; the single read port of the entry
//   memory sets this order. Reset clears head, tail and the per-slot valid
//   and ready flags; the entry memory needs no clearing.
//   While the receiver stalls, the output register holds its result, the
//   unit waits in its current step and takes no new command.
// ----------------------------------------------------------------------------
`default_nettype none

module reorder_buffer_commit_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rbc_in_if.sink    i_in,
    rbc_out_if.source o_out
);
    import rbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_RESOLVE = 3'b010,
        ST_RETIRE  = 3'b100
    } t_state;

    // Control registers
    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_head, n_head;
    logic [IDX_W-1:0]       r_tail, n_tail;
    logic [ROB_DEPTH-1:0]   r_valid, n_valid;
    logic [ROB_DEPTH-1:0]   r_ready, n_ready;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_misp, n_misp;

    // Memory and output side
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    t_entry                 ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry                 rd_entry;
    logic                   push;
    t_result                res;
    logic                   out_can_accept;

    // Decode helpers
    logic                   in_ready;
    logic                   buf_full;
    logic [IDX_W-1:0]       cmd_idx;
    logic                   idx_ok;
    logic [IDX_W-1:0]       head_nxt;
    logic [IDX_W-1:0]       tail_nxt;
    t_ekind                 alloc_kind;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        if (p == IDX_W'(ROB_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign rd_entry   = t_entry'(ram_rdata);
    assign head_nxt   = wrap_inc(r_head);
    assign tail_nxt   = wrap_inc(r_tail);
    assign buf_full   = (tail_nxt == r_head);
    assign cmd_idx    = IDX_W'(i_in.entry_index);
    assign idx_ok     = (32'(i_in.entry_index) < 32'(ROB_DEPTH)) && r_valid[cmd_idx];
    assign in_ready   = (r_state == ST_IDLE) && out_can_accept;
    assign i_in.ready = in_ready;

    // Kind three is kept as a register writer
    always_comb begin
        if (i_in.entry_kind == EK_STORE) begin
            alloc_kind = EK_STORE;
        end else if (i_in.entry_kind == EK_BRANCH) begin
            alloc_kind = EK_BRANCH;
        end else begin
            alloc_kind = EK_REG;
        end
    end

    // Command sequencer: one memory access per cycle, so a read never meets
    // a write to the same entry in the same cycle
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_valid   = r_valid;
        n_ready   = r_ready;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_misp    = r_misp;
        ram_we    = 1'b0;
        ram_waddr = r_tail;
        ram_wdata = rd_entry;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        push      = 1'b0;
        res       = '0;
        res.kind       = RK_NONE;
        res.error_code = ERR_NONE;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid && in_ready) begin
                    case (t_cmd'(i_in.cmd))
                        CMD_ALLOC: begin
                            push     = 1'b1;
                            res.kind = RK_ALLOC_ACK;
                            res.last = 1'b1;
                            if (buf_full) begin
                                res.error_code = ERR_FULL;
                                res.is_full    = 1'b1;
                            end else begin
                                ram_we                = 1'b1;
                                ram_waddr             = r_tail;
                                ram_wdata.kind        = alloc_kind;
                                ram_wdata.wrong_path  = 1'b0;
                                ram_wdata.dest_reg    = i_in.arch_reg;
                                ram_wdata.fresh_alias = i_in.fresh_phys;
                                ram_wdata.stale_alias = i_in.stale_phys;
                                ram_wdata.store_tag   = i_in.store_id;
                                n_valid[r_tail]       = 1'b1;
                                n_ready[r_tail]       = 1'b0;
                                n_tail                = tail_nxt;
                                res.slot              = SLOT_W'(r_tail);
                                res.is_full           = (wrap_inc(tail_nxt) == r_head);
                            end
                        end
                        CMD_MARK, CMD_RESOLVE: begin
                            if (!idx_ok) begin
                                push           = 1'b1;
                                res.kind       = RK_MARK_ACK;
                                res.slot       = i_in.entry_index;
                                res.error_code = ERR_NOT_VALID;
                                res.is_full    = buf_full;
                                res.last       = 1'b1;
                            end else if (i_in.cmd == CMD_MARK) begin
                                n_ready[cmd_idx] = 1'b1;
                                push             = 1'b1;
                                res.kind         = RK_MARK_ACK;
                                res.slot         = i_in.entry_index;
                                res.is_full      = buf_full;
                                res.last         = 1'b1;
                            end else begin
                                // Fetch the entry to check its kind
                                ram_re    = 1'b1;
                                ram_raddr = cmd_idx;
                                n_idx     = cmd_idx;
                                n_misp    = i_in.mispredicted;
                                n_state   = ST_RESOLVE;
                            end
                        end
                        CMD_COMMIT: begin
                            if (r_valid[r_head] && r_ready[r_head]) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_cnt     = '0;
                                n_state   = ST_RETIRE;
                            end else begin
                                push        = 1'b1;
                                res.kind    = RK_NONE;
                                res.is_full = buf_full;
                                res.last    = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RESOLVE: begin
                if (out_can_accept) begin
                    push        = 1'b1;
                    res.kind    = RK_MARK_ACK;
                    res.slot    = SLOT_W'(r_idx);
                    res.is_full = buf_full;
                    res.last    = 1'b1;
                    if (rd_entry.kind != EK_BRANCH) begin
                        res.error_code = ERR_NOT_BRANCH;
                    end else begin
                        // Write back the outcome
                        ram_we               = 1'b1;
                        ram_waddr            = r_idx;
                        ram_wdata            = rd_entry;
                        ram_wdata.wrong_path = r_misp;
                        n_ready[r_idx]       = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end

            ST_RETIRE: begin
                if (out_can_accept) begin
                    push     = 1'b1;
                    res.slot = SLOT_W'(r_head);
                    case (rd_entry.kind)
                        EK_STORE: begin
                            res.kind         = RK_RET_STORE;
                            res.store_to_run = rd_entry.store_tag;
                        end
                        EK_BRANCH: begin
                            res.kind = rd_entry.wrong_path ? RK_FLUSH : RK_RET_BR;
                        end
                        default: begin
                            res.kind             = RK_RET_REG;
                            res.retire_arch_reg  = rd_entry.dest_reg;
                            res.retire_new_alias = rd_entry.fresh_alias;
                            res.freed_alias      = rd_entry.stale_alias;
                        end
                    endcase

                    if ((rd_entry.kind == EK_BRANCH) && rd_entry.wrong_path) begin
                        // Flush everything younger and restart empty
                        n_valid  = '0;
                        n_ready  = '0;
                        n_head   = head_nxt;
                        n_tail   = head_nxt;
                        res.last = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_valid[r_head] = 1'b0;
                        n_ready[r_head] = 1'b0;
                        n_head          = head_nxt;
                        if ((r_cnt != CNT_W'(RETIRE_WIDTH - 1)) &&
                            r_valid[head_nxt] && r_ready[head_nxt]) begin
                            // Advance to the next ready entry
                            ram_re    = 1'b1;
                            ram_raddr = head_nxt;
                            n_cnt     = r_cnt + 1'b1;
                        end else begin
                            res.last = 1'b1;
                            n_state  = ST_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_valid <= '0;
            r_ready <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_valid <= n_valid;
            r_ready <= n_ready;
            r_cnt   <= n_cnt;
        end
    end

    // Held command operands
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_misp <= n_misp;
    end

    rbc_entry_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ROB_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rbc_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_res        (res),
        .o_can_accept (out_can_accept),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rbc_entry_ram.sv =====
// ----------------------------------------------------------------------------
// rbc_entry_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_entry_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rbc_out_reg.sv =====
// ----------------------------------------------------------------------------
// rbc_out_reg
// Result output register: holds one result until the receiver takes it and
// accepts a new one in the cycle the held one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rbc_pkg::t_result i_res,
    output logic                  o_can_accept,
    rbc_out_if.source             o_out
);
    import rbc_pkg::*;

    logic    r_full;
    t_result r_res;

    assign o_can_accept = !r_full || o_out.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_push) begin
            r_full <= 1'b1;
        end else if (o_out.ready) begin
            r_full <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    // Drive the channel
    assign o_out.valid            = r_full;
    assign o_out.kind             = r_res.kind;
    assign o_out.slot             = r_res.slot;
    assign o_out.retire_arch_reg  = r_res.retire_arch_reg;
    assign o_out.retire_new_alias = r_res.retire_new_alias;
    assign o_out.freed_alias      = r_res.freed_alias;
    assign o_out.store_to_run     = r_res.store_to_run;
    assign o_out.error_code       = r_res.error_code;
    assign o_out.is_full          = r_res.is_full;
    assign o_out.last             = r_res.last;

endmodule

`default_nettype wire

// ===== rtl/core/rbc_checker.sv =====
// ----------------------------------------------------------------------------
// rbc_checker
// Port-level checks of the reorder buffer commit unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [rbc_pkg::RKIND_W-1:0] i_out_kind,
    input wire logic [rbc_pkg::SLOT_W-1:0]  i_out_slot,
    input wire logic [rbc_pkg::ERR_W-1:0]   i_out_error,
    input wire logic                        i_out_full,
    input wire logic                        i_out_last
);
    import rbc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_slot) &&
            $stable(i_out_last))
        else $error("stalled result changed");

    // Single-result commands always close their step
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == RK_ALLOC_ACK || i_out_kind == RK_MARK_ACK ||
                        i_out_kind == RK_NONE || i_out_kind == RK_FLUSH)
            |-> i_out_last)
        else $error("single result without last");

    // A retirement leaves room and carries no error
    a_retire_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == RK_RET_REG || i_out_kind == RK_RET_STORE ||
                        i_out_kind == RK_RET_BR || i_out_kind == RK_FLUSH)
            |-> (i_out_error == ERR_NONE) && !i_out_full)
        else $error("retirement reported error or full");

    // A rejected allocate reports a full buffer on slot zero
    a_alloc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == RK_ALLOC_ACK) && (i_out_error == ERR_FULL)
            |-> i_out_full && (i_out_slot == '0))
        else $error("rejected allocate inconsistent");

endmodule

bind reorder_buffer_commit_unit rbc_checker u_rbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_slot  (o_out.slot),
    .i_out_error (o_out.error_code),
    .i_out_full  (o_out.is_full),
    .i_out_last  (o_out.last)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reorder buffer commit unit. Commands go in
// over the valid/ready input channel: first a short directed table, then
// random command streams that build up, complete and retire entries. Every
// accepted command runs through a local shadow of the buffer, and each
// result transfer on the output channel is matched against the oldest
// result still owed, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rbc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 7;
    localparam int RAND_ITEMS   = 260;
    localparam int FILL_AT      = 100;
    localparam int HOLD_AT      = 150;
    localparam int PAUSE_AT     = 220;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 50;

    // One command as offered on the input channel
    typedef struct {
        t_cmd                 cmd;
        logic [EKIND_W-1:0]   entry_kind;
        logic [AREG_W-1:0]    arch_reg;
        logic [ALIAS_W-1:0]   fresh_phys;
        logic [ALIAS_W-1:0]   stale_phys;
        logic [SID_W-1:0]     store_id;
        logic [SLOT_W-1:0]    entry_index;
        logic                 mispredicted;
        bit                   typed;
        t_result              want;
    } t_rob_cmd;

    logic clk;
    logic rst_n;

    rbc_in_if  in_ch();
    rbc_out_if out_ch();

    reorder_buffer_commit_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the buffer
    bit                 shadow_valid [ROB_DEPTH];
    bit                 shadow_ready [ROB_DEPTH];
    t_ekind             shadow_kind  [ROB_DEPTH];
    logic               shadow_wrong [ROB_DEPTH];
    logic [AREG_W-1:0]  shadow_dest  [ROB_DEPTH];
    logic [ALIAS_W-1:0] shadow_fresh [ROB_DEPTH];
    logic [ALIAS_W-1:0] shadow_stale [ROB_DEPTH];
    logic [SID_W-1:0]   shadow_tag   [ROB_DEPTH];
    logic [IDX_W-1:0]   shadow_head = '0;
    logic [IDX_W-1:0]   shadow_tail = '0;

    // Results of the last shadow step, and results the block still owes
    t_result step_res [RETIRE_WIDTH];
    int      step_cnt;
    t_result due_results [$];

    // Typed-in expectation riding along with the offered command
    bit      row_typed;
    t_result row_want;

    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned burst_left   = 0;
    bit          hold_req     = 1'b0;
    bit          hold_done    = 1'b0;

    // Clock
    initial clk = 1'b0;
    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic bit rob_is_full();
        return (shadow_tail + 1'b1) == shadow_head;
    endfunction

    function automatic t_result res_of(t_rkind k, logic [SLOT_W-1:0] s, t_err e);
        t_result r;
        r = '0;
        r.kind       = k;
        r.slot       = s;
        r.error_code = e;
        return r;
    endfunction

    task automatic emit(input t_result r);
        step_res[step_cnt] = r;
        step_cnt++;
    endtask

    // Advance the shadow buffer by one command and collect its results
    task automatic rob_advance(input t_cmd cmd, input logic [EKIND_W-1:0] ek,
                               input logic [AREG_W-1:0] areg,
                               input logic [ALIAS_W-1:0] nal,
                               input logic [ALIAS_W-1:0] oal,
                               input logic [SID_W-1:0] sid,
                               input logic [SLOT_W-1:0] idx, input logic misp);
        logic [IDX_W-1:0] h;
        t_err             err;
        t_result          r;
        step_cnt = 0;
        case (cmd)
            CMD_ALLOC: begin
                if (rob_is_full()) begin
                    emit(res_of(RK_ALLOC_ACK, '0, ERR_FULL));
                end else begin
                    h = shadow_tail;
                    shadow_valid[h] = 1'b1;
                    shadow_ready[h] = 1'b0;
                    // kind three is kept as a register writer
                    shadow_kind[h]  = (ek == 2'd3) ? EK_REG : t_ekind'(ek);
                    shadow_wrong[h] = 1'b0;
                    shadow_dest[h]  = areg;
                    shadow_fresh[h] = nal;
                    shadow_stale[h] = oal;
                    shadow_tag[h]   = sid;
                    shadow_tail     = h + 1'b1;
                    emit(res_of(RK_ALLOC_ACK, h, ERR_NONE));
                end
            end
            CMD_MARK, CMD_RESOLVE: begin
                err = ERR_NONE;
                if (!shadow_valid[idx]) begin
                    err = ERR_NOT_VALID;
                end else if (cmd == CMD_RESOLVE && shadow_kind[idx] != EK_BRANCH) begin
                    err = ERR_NOT_BRANCH;
                end else begin
                    shadow_ready[idx] = 1'b1;
                    if (cmd == CMD_RESOLVE) shadow_wrong[idx] = misp;
                end
                emit(res_of(RK_MARK_ACK, idx, err));
            end
            default: begin
                // Retire ready entries in order from the head
                for (int i = 0; i < RETIRE_WIDTH; i++) begin
                    h = shadow_head;
                    if (!shadow_valid[h] || !shadow_ready[h]) break;
                    if (shadow_kind[h] == EK_BRANCH && shadow_wrong[h]) begin
                        // Drop every younger entry and restart behind the branch
                        for (int s = 0; s < ROB_DEPTH; s++) begin
                            shadow_valid[s] = 1'b0;
                            shadow_ready[s] = 1'b0;
                        end
                        shadow_head = h + 1'b1;
                        shadow_tail = h + 1'b1;
                        emit(res_of(RK_FLUSH, h, ERR_NONE));
                        break;
                    end
                    r = res_of(RK_RET_REG, h, ERR_NONE);
                    case (shadow_kind[h])
                        EK_STORE: begin
                            r.kind         = RK_RET_STORE;
                            r.store_to_run = shadow_tag[h];
                        end
                        EK_BRANCH: r.kind = RK_RET_BR;
                        default: begin
                            r.retire_arch_reg  = shadow_dest[h];
                            r.retire_new_alias = shadow_fresh[h];
                            r.freed_alias      = shadow_stale[h];
                        end
                    endcase
                    emit(r);
                    shadow_valid[h] = 1'b0;
                    shadow_ready[h] = 1'b0;
                    shadow_head     = h + 1'b1;
                end
                if (step_cnt == 0) emit(res_of(RK_NONE, '0, ERR_NONE));
            end
        endcase
        for (int k = 0; k < step_cnt; k++) step_res[k].is_full = rob_is_full();
        step_res[step_cnt-1].last = 1'b1;
    endtask

    function automatic t_rob_cmd cmd_of(t_cmd cmd, logic [EKIND_W-1:0] ek,
                                        logic [AREG_W-1:0] areg,
                                        logic [ALIAS_W-1:0] nal,
                                        logic [ALIAS_W-1:0] oal,
                                        logic [SID_W-1:0] sid,
                                        logic [SLOT_W-1:0] idx, logic misp);
        t_rob_cmd c;
        c.cmd          = cmd;
        c.entry_kind   = ek;
        c.arch_reg     = areg;
        c.fresh_phys   = nal;
        c.stale_phys   = oal;
        c.store_id     = sid;
        c.entry_index  = idx;
        c.mispredicted = misp;
        c.typed        = 1'b0;
        c.want         = '0;
        return c;
    endfunction

    // Attach a single typed-in result to a table row
    function automatic t_rob_cmd with_want(t_rob_cmd c, t_rkind k,
                                           logic [SLOT_W-1:0] s, t_err e);
        c.typed     = 1'b1;
        c.want      = res_of(k, s, e);
        c.want.last = 1'b1;
        return c;
    endfunction

    // Random command, mostly well formed against the shadow state
    function automatic t_rob_cmd pick_random();
        t_rob_cmd         c;
        logic [IDX_W-1:0] occ6;
        logic [IDX_W-1:0] s;
        int unsigned      occ, roll, alloc_w, start;
        c = cmd_of(CMD_ALLOC, EKIND_W'($urandom_range(0, 3)), AREG_W'($urandom),
                   ALIAS_W'($urandom), ALIAS_W'($urandom), SID_W'($urandom),
                   SLOT_W'($urandom), 1'($urandom));
        occ6 = shadow_tail - shadow_head;
        occ  = occ6;
        roll = $urandom_range(0, 99);
        // noise: any command with any fields
        if (roll < 8) begin
            c.cmd = t_cmd'(CMD_W'($urandom));
            return c;
        end
        alloc_w = (occ < 8) ? 55 : ((occ > 48) ? 15 : 35);
        roll = $urandom_range(0, 99);
        if (roll < alloc_w) return c;
        if (roll < alloc_w + 25) begin
            c.cmd = CMD_MARK;
            if (occ != 0 && $urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 1) == 1)
                    c.entry_index = shadow_head +
                        IDX_W'($urandom_range(0, (occ > 8) ? 7 : occ - 1));
                else
                    c.entry_index = shadow_head + IDX_W'($urandom_range(0, occ - 1));
            end
            return c;
        end
        if (roll < alloc_w + 40) begin
            c.cmd          = CMD_RESOLVE;
            c.mispredicted = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) != 0) begin
                start = $urandom_range(0, ROB_DEPTH - 1);
                for (int k = 0; k < ROB_DEPTH; k++) begin
                    s = IDX_W'(start + k);
                    if (shadow_valid[s] && shadow_kind[s] == EK_BRANCH) begin
                        c.entry_index = s;
                        break;
                    end
                end
            end
            return c;
        end
        c.cmd = CMD_COMMIT;
        return c;
    endfunction

    // Offer one command in bursts with random gaps; return at the falling
    // edge after its transfer
    task automatic offer(input t_rob_cmd c);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= c.cmd;
        in_ch.entry_kind   <= c.entry_kind;
        in_ch.arch_reg     <= c.arch_reg;
        in_ch.fresh_phys   <= c.fresh_phys;
        in_ch.stale_phys   <= c.stale_phys;
        in_ch.store_id     <= c.store_id;
        in_ch.entry_index  <= c.entry_index;
        in_ch.mispredicted <= c.mispredicted;
        row_typed          <= c.typed;
        row_want           <= c.want;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge clk);
    endtask

    task automatic log_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic chk_field(input string name, input int got, input int want);
        if (got != want) log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Predict on every command transfer, check every result transfer
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                rob_advance(t_cmd'(in_ch.cmd), in_ch.entry_kind, in_ch.arch_reg,
                            in_ch.fresh_phys, in_ch.stale_phys, in_ch.store_id,
                            in_ch.entry_index, in_ch.mispredicted);
                if (row_typed) begin
                    due_results.push_back(row_want);
                end else begin
                    for (int k = 0; k < step_cnt; k++) due_results.push_back(step_res[k]);
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    log_mismatch($sformatf("result kind %0d slot %0d with nothing owed",
                                           out_ch.kind, out_ch.slot));
                end else begin
                    want = due_results.pop_front();
                    chk_field("kind", int'(out_ch.kind), int'(want.kind));
                    chk_field("slot", int'(out_ch.slot), int'(want.slot));
                    chk_field("retire_arch_reg", int'(out_ch.retire_arch_reg),
                              int'(want.retire_arch_reg));
                    chk_field("retire_new_alias", int'(out_ch.retire_new_alias),
                              int'(want.retire_new_alias));
                    chk_field("freed_alias", int'(out_ch.freed_alias),
                              int'(want.freed_alias));
                    chk_field("store_to_run", int'(out_ch.store_to_run),
                              int'(want.store_to_run));
                    chk_field("error_code", int'(out_ch.error_code), int'(want.error_code));
                    chk_field("is_full", int'(out_ch.is_full), int'(want.is_full));
                    chk_field("last", int'(out_ch.last), int'(want.last));
                end
            end
        end
    end

    // Result receiver: stall patterns, plus one long hold-off on request
    initial begin
        int unsigned mode, mode_left, hold_cnt;
        out_ch.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(negedge clk);
                    hold_cnt++;
                end
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(5, 40);
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ch.ready <= ($urandom_range(0, 2) == 0);
                    default: out_ch.ready <= ((mode_left % 3) != 0);
                endcase
                mode_left--;
            end
        end
    end

    // Hard stop on a hung run
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus
    initial begin
        t_rob_cmd directed_rows [$];
        t_rob_cmd c;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = '0;
        in_ch.entry_kind   = '0;
        in_ch.arch_reg     = '0;
        in_ch.fresh_phys   = '0;
        in_ch.stale_phys   = '0;
        in_ch.store_id     = '0;
        in_ch.entry_index  = '0;
        in_ch.mispredicted = 1'b0;
        row_typed          = 1'b0;
        row_want           = '0;
        rst_n              = 1'b0;

        // Empty buffer, bad indexes, one of each entry kind
        directed_rows.push_back(with_want(cmd_of(CMD_COMMIT, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_NONE, 6'd0, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_MARK, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd63, 1'b0), RK_MARK_ACK, 6'd63, ERR_NOT_VALID));
        directed_rows.push_back(with_want(cmd_of(CMD_RESOLVE, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b1), RK_MARK_ACK, 6'd0, ERR_NOT_VALID));
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, EK_REG, 5'd31, 7'd127,
            7'd127, 8'd255, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd0, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, EK_STORE, 5'd0, 7'd0, 7'd0,
            8'd255, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd1, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, EK_BRANCH, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd2, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, 2'd3, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd3, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_COMMIT, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_NONE, 6'd0, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_RESOLVE, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_MARK_ACK, 6'd0, ERR_NOT_BRANCH));
        directed_rows.push_back(with_want(cmd_of(CMD_MARK, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_MARK_ACK, 6'd0, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_MARK, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd1, 1'b0), RK_MARK_ACK, 6'd1, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_RESOLVE, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd2, 1'b0), RK_MARK_ACK, 6'd2, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_MARK, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd3, 1'b0), RK_MARK_ACK, 6'd3, ERR_NONE));
        // full-width retirement
        directed_rows.push_back(cmd_of(CMD_COMMIT, 2'd0, 5'd0, 7'd0, 7'd0, 8'd0, 6'd0,
            1'b0));
        // Branch marked ready without a resolve retires on the right path
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, EK_BRANCH, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd4, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_MARK, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd4, 1'b1), RK_MARK_ACK, 6'd4, ERR_NONE));
        directed_rows.push_back(cmd_of(CMD_COMMIT, 2'd0, 5'd0, 7'd0, 7'd0, 8'd0, 6'd0,
            1'b0));
        // Mispredicted branch at head flushes a younger ready entry
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, EK_BRANCH, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd5, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, EK_REG, 5'd31, 7'd0, 7'd127,
            8'd0, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd6, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_RESOLVE, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd5, 1'b1), RK_MARK_ACK, 6'd5, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_MARK, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd6, 1'b0), RK_MARK_ACK, 6'd6, ERR_NONE));
        directed_rows.push_back(cmd_of(CMD_COMMIT, 2'd0, 5'd0, 7'd0, 7'd0, 8'd0, 6'd0,
            1'b0));
        // Mark after a wrong resolve keeps the wrong outcome
        directed_rows.push_back(with_want(cmd_of(CMD_ALLOC, EK_BRANCH, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd0, 1'b0), RK_ALLOC_ACK, 6'd6, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_RESOLVE, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd6, 1'b1), RK_MARK_ACK, 6'd6, ERR_NONE));
        directed_rows.push_back(with_want(cmd_of(CMD_MARK, 2'd0, 5'd0, 7'd0, 7'd0,
            8'd0, 6'd6, 1'b0), RK_MARK_ACK, 6'd6, ERR_NONE));
        directed_rows.push_back(cmd_of(CMD_COMMIT, 2'd0, 5'd0, 7'd0, 7'd0, 8'd0, 6'd0,
            1'b0));

        // Hold reset, release on a falling edge
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i]) offer(directed_rows[i]);

        // Random streams with a fill to full, a long output hold-off and a
        // pause until every owed result is back
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == FILL_AT) begin
                while (!rob_is_full()) begin
                    c = pick_random();
                    c.cmd = CMD_ALLOC;
                    offer(c);
                end
                repeat (2) begin
                    c = pick_random();
                    c.cmd = CMD_ALLOC;
                    offer(c);
                end
            end
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == PAUSE_AT) begin
                in_ch.valid <= 1'b0;
                do @(negedge clk); while (due_results.size() != 0);
                burst_left = 0;
            end
            offer(pick_random());
        end

        // Drain and report
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0 && due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
